[src/uampq_pkg.sv]
package uampq_pkg;

	localparam int DEPTH_DEFAULT = 16;
	localparam int VALUE_W       = 32;
	localparam int PRIO_W        = 16;
	localparam int STATUS_W      = 2;
	localparam int COUNT_OUT_W   = 5;
	localparam int ENTRY_W       = VALUE_W + PRIO_W;

	localparam logic ACT_ENQ = 1'b0;
	localparam logic ACT_DEQ = 1'b1;

	typedef enum logic [STATUS_W-1:0] {
		STATUS_OK    = 2'd0,
		STATUS_EMPTY = 2'd1,
		STATUS_FULL  = 2'd2
	} status_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_SCAN,
		ST_WRITE,
		ST_FINISH
	} state_t;

	typedef struct packed {
		logic signed [VALUE_W-1:0] value;
		logic signed [PRIO_W-1:0]  prio;
	} entry_t;

endpackage

[src/uampq_ram.sv]
module uampq_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

[src/unsorted_array_min_priority_queue.sv]
// Enqueue, or any failed operation: the item is accepted in the idle state and its result
// is loaded into the output register from the finish state, before the next item is taken.
// Dequeue: each stored entry is read once through the single read port of the entry RAM,
// then the last entry is written into the freed slot. A stalled output holds the finish state.
// A new item is accepted while the previous result still waits in the output register.
// Reset empties the queue (count cleared) at once; the entry RAM is not cleared.
module unsorted_array_min_priority_queue #(
	parameter int DEPTH = uampq_pkg::DEPTH_DEFAULT
) (
	input  logic                                    clk,
	input  logic                                    arst_n,
	input  logic                                    in_valid,
	output logic                                    in_ready,
	input  logic                                    action,
	input  logic signed [uampq_pkg::VALUE_W-1:0]    item_value,
	input  logic signed [uampq_pkg::PRIO_W-1:0]     item_priority,
	output logic                                    out_valid,
	input  logic                                    out_ready,
	output logic signed [uampq_pkg::VALUE_W-1:0]    out_value,
	output logic [uampq_pkg::STATUS_W-1:0]          status,
	output logic [uampq_pkg::COUNT_OUT_W-1:0]       entry_count,
	output logic                                    is_empty,
	output logic                                    is_full
);

	import uampq_pkg::*;

	localparam int AW = $clog2(DEPTH);
	localparam int CW = $clog2(DEPTH + 1);
	localparam logic [CW-1:0] DEPTH_CW = CW'(DEPTH);

	state_t state_q, state_d;
	logic [CW-1:0] count_q;
	logic [CW-1:0] issue_q;
	logic          rd_vld_s1;
	logic [AW-1:0] rd_idx_s1;

	logic [AW-1:0]             best_idx_q;
	logic signed [PRIO_W-1:0]  best_prio_q;
	logic signed [VALUE_W-1:0] best_value_q;
	entry_t                    last_q;
	logic signed [VALUE_W-1:0] res_value_q;
	status_t                   res_status_q;

	logic                      out_valid_q;
	logic signed [VALUE_W-1:0] out_value_q;
	status_t                   out_status_q;
	logic [COUNT_OUT_W-1:0]    out_count_q;
	logic                      out_empty_q;
	logic                      out_full_q;

	logic          in_fire;
	logic          out_free;
	logic          mem_we;
	logic [AW-1:0] wr_addr;
	entry_t        wr_entry;
	logic          mem_re;
	logic [AW-1:0] rd_addr;
	logic [ENTRY_W-1:0] rd_data;
	entry_t        rd_entry;

	logic                      take_new;
	logic [AW-1:0]             best_idx_n;
	logic signed [PRIO_W-1:0]  best_prio_n;
	logic signed [VALUE_W-1:0] best_value_n;
	logic                      scan_last;
	logic                      issue_ok;
	logic                      deq_start;
	logic                      enq_ok;

	uampq_ram #(
		.WIDTH(ENTRY_W),
		.DEPTH(DEPTH)
	) u_ram (
		.clk  (clk),
		.we   (mem_we),
		.waddr(wr_addr),
		.wdata(wr_entry),
		.re   (mem_re),
		.raddr(rd_addr),
		.rdata(rd_data)
	);

	assign rd_entry  = entry_t'(rd_data);
	assign in_fire   = in_valid && in_ready;
	assign out_free  = !out_valid_q || out_ready;
	assign deq_start = in_fire && (action == ACT_DEQ) && (count_q != '0);
	assign enq_ok    = in_fire && (action == ACT_ENQ) && (count_q < DEPTH_CW);
	assign issue_ok  = (state_q == ST_SCAN) && (issue_q < count_q);

	// Running minimum; the first entry always seeds it, and a strict less-than
	// keeps the lowest index among equal priorities.
	assign take_new     = rd_vld_s1 && ((rd_idx_s1 == '0) || (rd_entry.prio < best_prio_q));
	assign best_idx_n   = take_new ? rd_idx_s1 : best_idx_q;
	assign best_prio_n  = take_new ? rd_entry.prio : best_prio_q;
	assign best_value_n = take_new ? rd_entry.value : best_value_q;
	assign scan_last    = rd_vld_s1 && (CW'(rd_idx_s1) == count_q - CW'(1));

	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				if (in_fire) begin
					state_d = deq_start ? ST_SCAN : ST_FINISH;
				end
			end
			ST_SCAN: begin
				if (scan_last) begin
					state_d = ST_WRITE;
				end
			end
			ST_WRITE: begin
				state_d = ST_FINISH;
			end
			ST_FINISH: begin
				if (out_free) begin
					state_d = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	// Reads happen only as a dequeue starts and during the scan, and writes only in
	// other cycles, so the sequencing itself keeps a read from meeting a write to the same entry.
	always_comb begin
		in_ready = 1'b0;
		mem_we   = 1'b0;
		wr_addr  = count_q[AW-1:0];
		wr_entry = '{value: item_value, prio: item_priority};
		mem_re   = 1'b0;
		rd_addr  = issue_q[AW-1:0];
		case (state_q)
			ST_IDLE: begin
				in_ready = 1'b1;
				mem_we   = enq_ok;
				mem_re   = deq_start;
				rd_addr  = '0;
			end
			ST_SCAN: begin
				mem_re = issue_ok;
			end
			ST_WRITE: begin
				mem_we   = 1'b1;
				wr_addr  = best_idx_q;
				wr_entry = last_q;
			end
			ST_FINISH: begin
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			count_q     <= '0;
			rd_vld_s1   <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			state_q   <= state_d;
			rd_vld_s1 <= mem_re;
			if (enq_ok) begin
				count_q <= count_q + CW'(1);
			end else if (state_q == ST_WRITE) begin
				count_q <= count_q - CW'(1);
			end
			if (state_q == ST_FINISH && out_free) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		rd_idx_s1 <= rd_addr;
		if (state_q == ST_IDLE) begin
			issue_q <= CW'(1);
		end else if (issue_ok) begin
			issue_q <= issue_q + CW'(1);
		end
		if (rd_vld_s1) begin
			best_idx_q   <= best_idx_n;
			best_prio_q  <= best_prio_n;
			best_value_q <= best_value_n;
		end
		if (scan_last) begin
			res_value_q <= best_value_n;
			last_q      <= rd_entry;
		end
		if (in_fire) begin
			res_value_q <= '0;
			if (action == ACT_ENQ && !enq_ok) begin
				res_status_q <= STATUS_FULL;
			end else if (action == ACT_DEQ && !deq_start) begin
				res_status_q <= STATUS_EMPTY;
			end else begin
				res_status_q <= STATUS_OK;
			end
		end
		if (state_q == ST_FINISH && out_free) begin
			out_value_q  <= res_value_q;
			out_status_q <= res_status_q;
			out_count_q  <= COUNT_OUT_W'(count_q);
			out_empty_q  <= (count_q == '0);
			out_full_q   <= (count_q == DEPTH_CW);
		end
	end

	assign out_valid   = out_valid_q;
	assign out_value   = out_value_q;
	assign status      = out_status_q;
	assign entry_count = out_count_q;
	assign is_empty    = out_empty_q;
	assign is_full     = out_full_q;

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= DEPTH_CW)
		else $error("entry count exceeds capacity");

	a_count_step: assert property (@(posedge clk) disable iff (!arst_n)
		(count_q != $past(count_q)) |->
		((count_q == $past(count_q) + CW'(1)) || (count_q == $past(count_q) - CW'(1))))
		else $error("entry count moved by more than one");

	a_no_write_in_scan: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_SCAN) |-> !mem_we)
		else $error("entry RAM written during a scan");

	a_best_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_WRITE) |-> (CW'(best_idx_q) < count_q))
		else $error("selected entry lies beyond the stored entries");

	a_result_from_finish: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid_q) |-> $past(state_q == ST_FINISH))
		else $error("result presented without a finished operation");

endmodule
